// File: rtl/cvx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvx_pkg
// Shared types for the convex hull block: control word of the product unit.
// ----------------------------------------------------------------------------
package cvx_pkg;

  // one product issue to the multiply-accumulate unit
  typedef struct packed {
    logic en;   // issue a product this cycle
    logic clr;  // start a new sum with this product
    logic sub;  // subtract this product instead of adding it
  } mac_ctl_t;

endpackage

// File: rtl/cvx_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvx_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module cvx_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/cvx_mac.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cvx_mac
// Shared signed multiply-accumulate unit: product register, then accumulator.
// A sum is done once its last product passes the product register, then the accumulator.
// ----------------------------------------------------------------------------
module cvx_mac #(
  parameter int OPW  = 17,
  parameter int ACCW = 35
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cvx_pkg::mac_ctl_t      ctl,
  input  logic signed [OPW-1:0]  op_a,
  input  logic signed [OPW-1:0]  op_b,
  output logic signed [ACCW-1:0] acc
);
  import cvx_pkg::*;

  mac_ctl_t                  pend_r;
  logic signed [2*OPW-1:0]   prod_r;
  logic signed [ACCW-1:0]    acc_r;
  logic signed [ACCW-1:0]    prod_ext;
  logic signed [ACCW-1:0]    base;

  assign prod_ext = ACCW'(prod_r);
  assign base     = pend_r.clr ? '0 : acc_r;
  assign acc      = acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= ctl;
    end
    prod_r <= op_a * op_b;
    if (pend_r.en) begin
      acc_r <= pend_r.sub ? base - prod_ext : base + prod_ext;
    end
  end

endmodule

// File: rtl/convex_hull_graham_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_graham_scan
// Graham scan convex hull over a streamed point set.
// ----------------------------------------------------------------------------
// Points load one beat per cycle into a point RAM (extra points past
// MAX_POINTS are dropped); the beat with tlast closes the set and starts the
// hull run, during which in_tready is low. The run finds the lowest-leftmost
// pivot and swaps it into entry 0, insertion-sorts by angle about the pivot
// with each compare done on one shared multiply-accumulate unit, drops
// collinear runs, runs the stack pass in place in the same RAM and pops the
// hull out top first, pivot last with tlast set, each vertex held until
// out_tready takes it. The single RAM read port and the shared multiplier
// set the pace: the sort is O(n^2) compares. Sets with fewer than three hull
// candidates give no output beats.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan #(
  parameter int MAX_POINTS = 64,
  parameter int COORD_BITS = 16
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // point_x, point_y, zero pad
  input  logic [((2*COORD_BITS+7)/8)*8-1:0]        in_tdata,
  input  logic                                     in_tlast,   // last_point
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // hull_x, hull_y, zero pad
  output logic [((2*COORD_BITS+7)/8)*8-1:0]        out_tdata,
  output logic                                     out_tlast   // hull_end
);
  import cvx_pkg::*;

  localparam int CB   = COORD_BITS;
  localparam int PW   = 2 * CB;
  localparam int TDW  = ((2 * CB + 7) / 8) * 8;
  localparam int D    = CB + 1;
  localparam int ACCW = 2 * D + 1;
  localparam int CW   = $clog2(MAX_POINTS + 1);
  localparam int IW   = $clog2(MAX_POINTS);

  localparam logic [5:0] S_LOAD   = 6'd0;
  localparam logic [5:0] S_PS_I   = 6'd1;
  localparam logic [5:0] S_PS_W   = 6'd2;
  localparam logic [5:0] S_PS_C   = 6'd3;
  localparam logic [5:0] S_SW_W   = 6'd4;
  localparam logic [5:0] S_SW_C   = 6'd5;
  localparam logic [5:0] S_SW_2   = 6'd6;
  localparam logic [5:0] S_SO_I   = 6'd7;
  localparam logic [5:0] S_SO_KW  = 6'd8;
  localparam logic [5:0] S_SO_K   = 6'd9;
  localparam logic [5:0] S_SO_J   = 6'd10;
  localparam logic [5:0] S_SO_JW  = 6'd11;
  localparam logic [5:0] S_SO_JD  = 6'd12;
  localparam logic [5:0] S_SO_PUT = 6'd13;
  localparam logic [5:0] S_CR1    = 6'd14;
  localparam logic [5:0] S_CR2    = 6'd15;
  localparam logic [5:0] S_CR3    = 6'd16;
  localparam logic [5:0] S_EV     = 6'd17;
  localparam logic [5:0] S_DS1    = 6'd18;
  localparam logic [5:0] S_DS2    = 6'd19;
  localparam logic [5:0] S_DS3    = 6'd20;
  localparam logic [5:0] S_DS4    = 6'd21;
  localparam logic [5:0] S_DS5    = 6'd22;
  localparam logic [5:0] S_DS6    = 6'd23;
  localparam logic [5:0] S_CO_I   = 6'd24;
  localparam logic [5:0] S_CO_AW  = 6'd25;
  localparam logic [5:0] S_CO_A   = 6'd26;
  localparam logic [5:0] S_CO_BW  = 6'd27;
  localparam logic [5:0] S_CO_B   = 6'd28;
  localparam logic [5:0] S_CO_PUT = 6'd29;
  localparam logic [5:0] S_CO_END = 6'd30;
  localparam logic [5:0] S_SC_I   = 6'd31;
  localparam logic [5:0] S_SC_RW  = 6'd32;
  localparam logic [5:0] S_SC_R   = 6'd33;
  localparam logic [5:0] S_SC_T   = 6'd34;
  localparam logic [5:0] S_SC_PW  = 6'd35;
  localparam logic [5:0] S_SC_P   = 6'd36;
  localparam logic [5:0] S_SC_QW  = 6'd37;
  localparam logic [5:0] S_SC_Q   = 6'd38;
  localparam logic [5:0] S_SC_PSH = 6'd39;
  localparam logic [5:0] S_OU_I   = 6'd40;
  localparam logic [5:0] S_OU_W   = 6'd41;
  localparam logic [5:0] S_OU_L   = 6'd42;
  localparam logic [5:0] S_OU_H   = 6'd43;
  localparam logic [5:0] S_DONE   = 6'd44;

  // what the cross product result is used for
  localparam logic [1:0] M_SORT = 2'd0;
  localparam logic [1:0] M_COL  = 2'd1;
  localparam logic [1:0] M_SCAN = 2'd2;

  logic [5:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] m_r, m_nxt;
  logic [CW-1:0] t_r, t_nxt;
  logic [IW-1:0] ra_r, ra_nxt;
  logic [IW-1:0] piv_idx_r, piv_idx_nxt;
  logic [PW-1:0] pv_r, pv_nxt;
  logic [PW-1:0] key_r, key_nxt;
  logic [PW-1:0] op_p_r, op_p_nxt;
  logic [PW-1:0] op_q_r, op_q_nxt;
  logic [PW-1:0] op_r_r, op_r_nxt;
  logic [1:0]    mode_r, mode_nxt;
  logic [CB-1:0] out_x_r, out_x_nxt;
  logic [CB-1:0] out_y_r, out_y_nxt;
  logic          out_end_r, out_end_nxt;
  logic          out_valid_r, out_valid_nxt;

  logic          we;
  logic [IW-1:0] waddr;
  logic [PW-1:0] wdata;
  logic [PW-1:0] rdata;

  mac_ctl_t                 mac_ctl;
  logic signed [D-1:0]      mac_a, mac_b;
  logic signed [ACCW-1:0]   mac_acc;
  logic                     acc_neg, acc_zero;

  logic signed [CB-1:0] rd_x, rd_y, pv_x, pv_y;
  logic signed [D-1:0]  px, py, qx, qy, rx, ry;
  logic [CW-1:0]        cnt_inc, i_inc, j_inc, j_dec, t_inc, t_dec, t_dec2, n_dec;

  assign rd_x = rdata[CB-1:0];
  assign rd_y = rdata[PW-1:CB];
  assign pv_x = pv_r[CB-1:0];
  assign pv_y = pv_r[PW-1:CB];

  assign px = {op_p_r[CB-1], op_p_r[CB-1:0]};
  assign py = {op_p_r[PW-1], op_p_r[PW-1:CB]};
  assign qx = {op_q_r[CB-1], op_q_r[CB-1:0]};
  assign qy = {op_q_r[PW-1], op_q_r[PW-1:CB]};
  assign rx = {op_r_r[CB-1], op_r_r[CB-1:0]};
  assign ry = {op_r_r[PW-1], op_r_r[PW-1:CB]};

  assign cnt_inc = cnt_r + CW'(1);
  assign i_inc   = i_r + CW'(1);
  assign j_inc   = j_r + CW'(1);
  assign j_dec   = j_r - CW'(1);
  assign t_inc   = t_r + CW'(1);
  assign t_dec   = t_r - CW'(1);
  assign t_dec2  = t_r - CW'(2);
  assign n_dec   = n_r - CW'(1);

  assign acc_neg  = mac_acc[ACCW-1];
  assign acc_zero = (mac_acc == '0);

  cvx_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS)
  ) u_pts (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (ra_r),
    .rdata (rdata)
  );

  cvx_mac #(
    .OPW  (D),
    .ACCW (ACCW)
  ) u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (mac_ctl),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .acc   (mac_acc)
  );

  assign in_tready  = (state_r == S_LOAD);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDW'({out_y_r, out_x_r});
  assign out_tlast  = out_end_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    m_nxt         = m_r;
    t_nxt         = t_r;
    ra_nxt        = ra_r;
    piv_idx_nxt   = piv_idx_r;
    pv_nxt        = pv_r;
    key_nxt       = key_r;
    op_p_nxt      = op_p_r;
    op_q_nxt      = op_q_r;
    op_r_nxt      = op_r_r;
    mode_nxt      = mode_r;
    out_x_nxt     = out_x_r;
    out_y_nxt     = out_y_r;
    out_end_nxt   = out_end_r;
    out_valid_nxt = out_valid_r;
    we            = 1'b0;
    waddr         = '0;
    wdata         = key_r;
    mac_ctl       = '0;
    mac_a         = '0;
    mac_b         = '0;

    unique case (state_r)
      S_LOAD: begin
        if (in_tvalid) begin
          if (cnt_r < CW'(MAX_POINTS)) begin
            we      = 1'b1;
            waddr   = cnt_r[IW-1:0];
            wdata   = in_tdata[PW-1:0];
            cnt_nxt = cnt_inc;
          end
          if (in_tlast) begin
            n_nxt     = (cnt_r < CW'(MAX_POINTS)) ? cnt_inc : cnt_r;
            i_nxt     = '0;
            state_nxt = (n_nxt < CW'(3)) ? S_DONE : S_PS_I;
          end
        end
      end
      // pivot search: lowest y, then lowest x, first in arrival order
      S_PS_I: begin
        if (i_r < n_r) begin
          ra_nxt    = i_r[IW-1:0];
          state_nxt = S_PS_W;
        end else begin
          ra_nxt    = '0;
          state_nxt = S_SW_W;
        end
      end
      S_PS_W: state_nxt = S_PS_C;
      S_PS_C: begin
        if (i_r == '0 || rd_y < pv_y || (rd_y == pv_y && rd_x < pv_x)) begin
          pv_nxt      = rdata;
          piv_idx_nxt = i_r[IW-1:0];
        end
        i_nxt     = i_inc;
        state_nxt = S_PS_I;
      end
      S_SW_W: state_nxt = S_SW_C;
      S_SW_C: begin
        we        = 1'b1;
        waddr     = piv_idx_r;
        wdata     = rdata;
        state_nxt = S_SW_2;
      end
      S_SW_2: begin
        we        = 1'b1;
        waddr     = '0;
        wdata     = pv_r;
        i_nxt     = CW'(2);
        state_nxt = S_SO_I;
      end
      // insertion sort by angle about the pivot
      S_SO_I: begin
        if (i_r < n_r) begin
          ra_nxt    = i_r[IW-1:0];
          state_nxt = S_SO_KW;
        end else begin
          i_nxt     = CW'(1);
          m_nxt     = CW'(1);
          state_nxt = S_CO_I;
        end
      end
      S_SO_KW: state_nxt = S_SO_K;
      S_SO_K: begin
        key_nxt   = rdata;
        j_nxt     = i_r - CW'(1);
        state_nxt = S_SO_J;
      end
      S_SO_J: begin
        if (j_r != '0) begin
          ra_nxt    = j_r[IW-1:0];
          state_nxt = S_SO_JW;
        end else begin
          state_nxt = S_SO_PUT;
        end
      end
      S_SO_JW: state_nxt = S_SO_JD;
      S_SO_JD: begin
        op_p_nxt  = pv_r;
        op_q_nxt  = key_r;
        op_r_nxt  = rdata;
        mode_nxt  = M_SORT;
        state_nxt = S_CR1;
      end
      S_SO_PUT: begin
        we        = 1'b1;
        waddr     = j_inc[IW-1:0];
        wdata     = key_r;
        i_nxt     = i_inc;
        state_nxt = S_SO_I;
      end
      // cross product (r-q) x (q-p), negative on a left turn
      S_CR1: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        mac_a     = qy - py;
        mac_b     = rx - qx;
        state_nxt = S_CR2;
      end
      S_CR2: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        mac_a     = qx - px;
        mac_b     = ry - qy;
        state_nxt = S_CR3;
      end
      S_CR3: state_nxt = S_EV;
      S_EV: begin
        case (mode_r)
          M_SORT: begin
            if (acc_neg) begin
              we        = 1'b1;
              waddr     = j_inc[IW-1:0];
              wdata     = op_r_r;
              j_nxt     = j_dec;
              state_nxt = S_SO_J;
            end else if (acc_zero) begin
              state_nxt = S_DS1;
            end else begin
              state_nxt = S_SO_PUT;
            end
          end
          M_COL: begin
            if (acc_zero) begin
              i_nxt     = i_inc;
              state_nxt = S_CO_I;
            end else begin
              state_nxt = S_CO_PUT;
            end
          end
          M_SCAN: begin
            if (acc_neg) begin
              state_nxt = S_SC_PSH;
            end else begin
              t_nxt     = t_dec;
              state_nxt = S_SC_T;
            end
          end
          default: state_nxt = S_DONE;
        endcase
      end
      // equal angle: farther point sorts later
      S_DS1: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b1, sub: 1'b0};
        mac_a     = rx - px;
        mac_b     = rx - px;
        state_nxt = S_DS2;
      end
      S_DS2: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b0, sub: 1'b0};
        mac_a     = ry - py;
        mac_b     = ry - py;
        state_nxt = S_DS3;
      end
      S_DS3: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        mac_a     = qx - px;
        mac_b     = qx - px;
        state_nxt = S_DS4;
      end
      S_DS4: begin
        mac_ctl   = '{en: 1'b1, clr: 1'b0, sub: 1'b1};
        mac_a     = qy - py;
        mac_b     = qy - py;
        state_nxt = S_DS5;
      end
      S_DS5: state_nxt = S_DS6;
      S_DS6: begin
        if (!acc_neg && !acc_zero) begin
          we        = 1'b1;
          waddr     = j_inc[IW-1:0];
          wdata     = op_r_r;
          j_nxt     = j_dec;
          state_nxt = S_SO_J;
        end else begin
          state_nxt = S_SO_PUT;
        end
      end
      // keep only the farthest of each run collinear with the pivot
      S_CO_I: begin
        if (i_r < n_r) begin
          ra_nxt    = i_r[IW-1:0];
          state_nxt = S_CO_AW;
        end else begin
          state_nxt = S_CO_END;
        end
      end
      S_CO_AW: state_nxt = S_CO_A;
      S_CO_A: begin
        op_q_nxt = rdata;
        if (i_r < n_dec) begin
          ra_nxt    = i_inc[IW-1:0];
          state_nxt = S_CO_BW;
        end else begin
          state_nxt = S_CO_PUT;
        end
      end
      S_CO_BW: state_nxt = S_CO_B;
      S_CO_B: begin
        op_p_nxt  = pv_r;
        op_r_nxt  = rdata;
        mode_nxt  = M_COL;
        state_nxt = S_CR1;
      end
      S_CO_PUT: begin
        we        = 1'b1;
        waddr     = m_r[IW-1:0];
        wdata     = op_q_r;
        m_nxt     = m_r + CW'(1);
        i_nxt     = i_inc;
        state_nxt = S_CO_I;
      end
      S_CO_END: begin
        if (m_r < CW'(3)) begin
          state_nxt = S_DONE;
        end else begin
          t_nxt     = CW'(3);
          i_nxt     = CW'(3);
          state_nxt = S_SC_I;
        end
      end
      // stack pass; stack lives in the low entries of the same RAM
      S_SC_I: begin
        if (i_r < m_r) begin
          ra_nxt    = i_r[IW-1:0];
          state_nxt = S_SC_RW;
        end else begin
          state_nxt = S_OU_I;
        end
      end
      S_SC_RW: state_nxt = S_SC_R;
      S_SC_R: begin
        op_r_nxt  = rdata;
        state_nxt = S_SC_T;
      end
      S_SC_T: begin
        if (t_r > CW'(1)) begin
          ra_nxt    = t_dec2[IW-1:0];
          state_nxt = S_SC_PW;
        end else begin
          state_nxt = S_SC_PSH;
        end
      end
      S_SC_PW: state_nxt = S_SC_P;
      S_SC_P: begin
        op_p_nxt  = rdata;
        ra_nxt    = t_dec[IW-1:0];
        state_nxt = S_SC_QW;
      end
      S_SC_QW: state_nxt = S_SC_Q;
      S_SC_Q: begin
        op_q_nxt  = rdata;
        mode_nxt  = M_SCAN;
        state_nxt = S_CR1;
      end
      S_SC_PSH: begin
        we        = 1'b1;
        waddr     = t_r[IW-1:0];
        wdata     = op_r_r;
        t_nxt     = t_inc;
        i_nxt     = i_inc;
        state_nxt = S_SC_I;
      end
      // pop the stack out, top first
      S_OU_I: begin
        if (t_r != '0) begin
          ra_nxt    = t_dec[IW-1:0];
          state_nxt = S_OU_W;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_OU_W: state_nxt = S_OU_L;
      S_OU_L: begin
        out_x_nxt     = rdata[CB-1:0];
        out_y_nxt     = rdata[PW-1:CB];
        out_end_nxt   = (t_r == CW'(1));
        out_valid_nxt = 1'b1;
        t_nxt         = t_dec;
        state_nxt     = S_OU_H;
      end
      S_OU_H: begin
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_OU_I;
        end
      end
      S_DONE: begin
        cnt_nxt   = '0;
        t_nxt     = '0;
        state_nxt = S_LOAD;
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cnt_r       <= '0;
      n_r         <= '0;
      i_r         <= '0;
      j_r         <= '0;
      m_r         <= '0;
      t_r         <= '0;
      ra_r        <= '0;
      piv_idx_r   <= '0;
      pv_r        <= '0;
      mode_r      <= M_SORT;
      out_valid_r <= 1'b0;
      out_end_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      n_r         <= n_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      m_r         <= m_nxt;
      t_r         <= t_nxt;
      ra_r        <= ra_nxt;
      piv_idx_r   <= piv_idx_nxt;
      pv_r        <= pv_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
      out_end_r   <= out_end_nxt;
    end
    key_r   <= key_nxt;
    op_p_r  <= op_p_nxt;
    op_q_r  <= op_q_nxt;
    op_r_r  <= op_r_nxt;
    out_x_r <= out_x_nxt;
    out_y_r <= out_y_nxt;
  end

`ifndef SYNTHESIS
  a_no_load_while_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !out_tvalid)
    else $error("input taken while a hull beat is pending");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count past capacity");

  a_stack_in_place: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SC_I) |-> (t_r <= i_r && i_r <= m_r))
    else $error("stack overran the unread points");

  a_end_is_pivot: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (t_r == '0))
    else $error("hull end flagged before the stack emptied");
`endif

endmodule

// File: bench/convex_hull_graham_scan_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// convex_hull_graham_scan_test
// Self-checking bench for the Graham scan convex hull block.
// ----------------------------------------------------------------------------
// Streams point sets into the block and predicts every hull vertex with an
// independent scan model: lowest-leftmost pivot, stable angular sort, keeping
// only the farthest of each run collinear with the pivot, stack scan, pop-out
// top first. Runs a short directed table, then random sets under several
// idle/stall mixes, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
module convex_hull_graham_scan_test;

  localparam int MAXP = 64;
  localparam int CB = 16;
  localparam int DW = ((2*CB+7)/8)*8;

  typedef struct {
    logic signed [CB-1:0] x;
    logic signed [CB-1:0] y;
  } pt_t;

  typedef struct {
    logic [CB-1:0] x;
    logic [CB-1:0] y;
    logic          last;
  } vtx_t;

  logic clk = 0;
  logic rst_n = 0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [DW-1:0] in_tdata = '0;
  logic in_tlast = 0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [DW-1:0] out_tdata;
  logic out_tlast;

  convex_hull_graham_scan #(.MAX_POINTS(MAXP), .COORD_BITS(CB)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready),
    .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tlast(out_tlast)
  );

  always #5 clk = ~clk;

  pt_t  set_pts[$];
  vtx_t hull_q[$];
  int   errors = 0;
  int   send_idle = 0;
  int   recv_stall = 0;
  int   hold_cycles = 0;

  // signed cross of (r-q) x (q-p), sign convention of the scan
  function automatic longint turn(pt_t p, pt_t q, pt_t r);
    longint a, b;
    a = (longint'(q.y) - p.y) * (longint'(r.x) - q.x);
    b = (longint'(q.x) - p.x) * (longint'(r.y) - q.y);
    return a - b;
  endfunction

  function automatic longint dist2(pt_t a, pt_t b);
    longint dx, dy;
    dx = longint'(a.x) - b.x;
    dy = longint'(a.y) - b.y;
    return dx*dx + dy*dy;
  endfunction

  function automatic bit sorts_later(pt_t piv, pt_t a, pt_t b);
    if (turn(piv, b, a) < 0) return 1;
    if (turn(piv, a, b) == 0) return dist2(piv, a) > dist2(piv, b);
    return 0;
  endfunction

  task automatic predict_hull();
    pt_t p[$];
    pt_t kept[$];
    pt_t stk[$];
    pt_t t, key, piv;
    int n, pi, j, i;
    vtx_t v;
    p = set_pts;
    n = p.size();
    set_pts.delete();
    if (n < 3) return;
    pi = 0;
    for (i = 1; i < n; i++)
      if (p[i].y < p[pi].y || (p[i].y == p[pi].y && p[i].x < p[pi].x)) pi = i;
    t = p[0]; p[0] = p[pi]; p[pi] = t;
    piv = p[0];
    for (i = 2; i < n; i++) begin
      key = p[i];
      j = i - 1;
      while (j >= 1 && sorts_later(piv, p[j], key)) begin
        p[j+1] = p[j];
        j--;
      end
      p[j+1] = key;
    end
    kept.push_back(p[0]);
    for (i = 1; i < n; i++) begin
      while (i < n-1 && turn(piv, p[i], p[i+1]) == 0) i++;
      kept.push_back(p[i]);
    end
    if (kept.size() < 3) return;
    stk.push_back(kept[0]); stk.push_back(kept[1]); stk.push_back(kept[2]);
    for (i = 3; i < kept.size(); i++) begin
      while (stk.size() > 1 && !(turn(stk[stk.size()-2], stk[stk.size()-1], kept[i]) < 0))
        void'(stk.pop_back());
      stk.push_back(kept[i]);
    end
    while (stk.size() > 0) begin
      t = stk.pop_back();
      v.x = t.x; v.y = t.y; v.last = (stk.size() == 0);
      hull_q.push_back(v);
    end
  endtask

  // in_tready only follows the state, so it is sampled mid-cycle
  task automatic send_point(logic [CB-1:0] x, logic [CB-1:0] y, logic last);
    pt_t pt;
    if ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
    in_tvalid <= 1;
    in_tdata <= DW'({y, x});
    in_tlast <= last;
    forever begin
      @(negedge clk);
      if (in_tready) begin
        @(posedge clk);
        break;
      end
    end
    pt.x = x; pt.y = y;
    if (set_pts.size() < MAXP) set_pts.push_back(pt);
    if (last) predict_hull();
  endtask

  // random set; mostly small, a few full or overfull
  task automatic random_set(int n, int span);
    for (int i = 0; i < n; i++)
      send_point(CB'($urandom_range(2*span) - span), CB'($urandom_range(2*span) - span),
                 i == n-1);
  endtask

  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 0;
    end else
      out_tready <= ($urandom_range(99) >= recv_stall);
    if (rst_n && out_tvalid && out_tready) begin
      if (hull_q.size() == 0) begin
        $display("%0t unexpected beat: x=%h y=%h last=%b", $time,
                 out_tdata[CB-1:0], out_tdata[2*CB-1:CB], out_tlast);
        errors++;
      end else begin
        vtx_t e;
        e = hull_q.pop_front();
        if (out_tdata[CB-1:0] !== e.x || out_tdata[2*CB-1:CB] !== e.y ||
            out_tlast !== e.last) begin
          $display("%0t mismatch: expected x=%h y=%h last=%b, actual x=%h y=%h last=%b",
                   $time, e.x, e.y, e.last, out_tdata[CB-1:0], out_tdata[2*CB-1:CB],
                   out_tlast);
          errors++;
        end
      end
    end
  end

  task automatic drain();
    in_tvalid <= 0;
    while (hull_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // directed rows: x, y, last
  typedef struct { logic [CB-1:0] x; logic [CB-1:0] y; logic last; } row_t;
  row_t dir_tab[] = '{
    '{16'h8000, 16'h8000, 0}, '{16'h7fff, 16'h8000, 0}, '{16'h7fff, 16'h7fff, 0},
    '{16'h8000, 16'h7fff, 1},                          // extreme square
    '{16'd1, 16'd1, 0}, '{16'd2, 16'd2, 1},           // too few points
    '{16'd0, 16'd0, 0}, '{16'd1, 16'd1, 0}, '{16'd2, 16'd2, 1}, // all collinear
    '{16'd0, 16'd0, 0}, '{16'd0, 16'd0, 0}, '{16'd4, 16'd0, 0},
    '{16'd2, 16'd0, 0}, '{16'd4, 16'd4, 0}, '{16'd2, 16'd2, 0},
    '{16'd0, 16'd4, 0}, '{16'd1, 16'd3, 1},           // pivot dupes, collinear
    '{16'd5, 16'd5, 0}, '{16'd5, 16'd5, 0}, '{16'd9, 16'd5, 0},
    '{16'd5, 16'd9, 0}, '{16'd9, 16'd5, 1}            // equal keys
  };

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (dir_tab[i]) send_point(dir_tab[i].x, dir_tab[i].y, dir_tab[i].last);
    drain();
    // overfull set: points past capacity dropped
    random_set(MAXP + 3, 32768);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle  = (ph == 1 || ph == 3) ? (ph == 1 ? 73 : 35) : 0;
      recv_stall = (ph == 2 || ph == 3) ? (ph == 2 ? 73 : 35) : 0;
      for (int s = 0; s < 9; s++)
        random_set($urandom_range(3, 12), ($urandom_range(3) == 0) ? 32768 : 20);
    end
    // long receiver hold-off while sets keep coming
    send_idle = 0; recv_stall = 0;
    hold_cycles = 3000;
    for (int s = 0; s < 4; s++) random_set($urandom_range(4, 10), 32768);
    drain();
    random_set(MAXP, 32768);
    drain();
    for (int s = 0; s < 8; s++) random_set($urandom_range(3, 8), 4);
    drain();
    if (errors == 0 && hull_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
